[hw/rtl/mwpo_pkg.sv]
package mwpo_pkg;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_PULSE    = 3'd4,
    WAVE_NOISE    = 3'd5
  } wave_t;

  localparam logic [2:0] CFG_WAVEFORM      = 3'd0;
  localparam logic [2:0] CFG_AMPLITUDE     = 3'd1;
  localparam logic [2:0] CFG_PULSE_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_MIN_STEP      = 3'd3;
  localparam logic [2:0] CFG_VOLTAGE_RANGE = 3'd4;

  localparam logic [15:0] AMPLITUDE_RESET   = 16'd16384;
  localparam logic [15:0] PULSE_WIDTH_RESET = 16'd32768;
  localparam logic [31:0] MIN_STEP_RESET    = 32'd1;
  localparam logic [1:0]  RANGE_RESET       = 2'd1;

  localparam logic [15:0] PW_MIN     = 16'd3277;
  localparam logic [15:0] PW_MAX     = 16'd62259;
  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED  = 32'd1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [2:0]  waveform;
    logic [15:0] amplitude;
    logic [15:0] pulse_width;
    logic [31:0] min_step;
    logic [1:0]  voltage_range;
  } cfg_t;

  // Taylor series of sin(a), a in Q30 radians, scaled to 32767 and rounded
  function automatic logic [15:0] sine_point(input logic [63:0] a);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    term = a;
    sum  = a;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd6;
    sum  = sum - term;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd20;
    sum  = sum + term;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd42;
    sum  = sum - term;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd72;
    sum  = sum + term;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd110;
    sum  = sum - term;
    term = (term * a) >> 30;
    term = (term * a) >> 30;
    term = term / 64'd156;
    sum  = sum + term;
    r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  function automatic logic [4:0] range_volts(input logic [1:0] range_code);
    logic [4:0] v;
    case (range_code)
      2'd0: v = 5'd5;
      2'd1: v = 5'd10;
      2'd2: v = 5'd12;
      default: v = 5'd15;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/mwpo_phase.sv]
module mwpo_phase #(
  parameter int PHASE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [31:0]           phase_step,
  input  logic                  sync,
  input  mwpo_pkg::cfg_t        cfg,
  output logic [PHASE_BITS-1:0] phase,
  output logic [31:0]           noise
);

  localparam int StepW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_base;
  logic [PHASE_BITS-1:0] phase_acc_next;
  logic [31:0]           step_use;
  logic [StepW-1:0]      step_wide;
  logic signed [32:0]    step_ext;
  logic signed [32:0]    min_ext;
  logic [31:0]           noise_next;

  assign step_ext = $signed({phase_step[31], phase_step});
  assign min_ext  = $signed({1'b0, cfg.min_step});
  assign step_use = (step_ext < min_ext) ? cfg.min_step : phase_step;
  assign step_wide = StepW'(step_use);

  assign phase_base     = sync ? '0 : phase_acc;
  assign phase_acc_next = phase_base + step_wide[PHASE_BITS-1:0];

  assign noise_next = (noise >> 1) ^ ({32{noise[0]}} & mwpo_pkg::LFSR_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      noise     <= mwpo_pkg::LFSR_SEED;
    end else if (accept) begin
      phase_acc <= phase_acc_next;
      if (cfg.waveform == mwpo_pkg::WAVE_NOISE) begin
        noise <= noise_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase <= phase_base;
    end
  end

endmodule

[hw/rtl/mwpo_wave.sv]
module mwpo_wave #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PHASE_BITS-1:0] phase,
  input  logic [31:0]           noise,
  input  mwpo_pkg::cfg_t        cfg,
  output logic signed [16:0]    raw
);

  localparam int QuadBits = $clog2(SINE_TABLE_DEPTH);

  logic [15:0]           rom [0:SINE_TABLE_DEPTH];
  logic [15:0]           u;
  logic [QuadBits+1:0]   pos;
  logic [QuadBits-1:0]   k;
  logic [QuadBits:0]     idx;
  logic signed [16:0]    mag;
  logic signed [17:0]    tri_d;
  logic signed [17:0]    tri_abs;
  logic [15:0]           pw;
  logic signed [16:0]    raw_next;

  for (genvar j = 0; j <= SINE_TABLE_DEPTH; j++) begin : g_rom
    localparam logic [63:0] Angle = (64'(j) * mwpo_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom[j] = mwpo_pkg::sine_point(Angle);
  end

  assign u   = phase[PHASE_BITS-1 -: 16];
  assign pos = phase[PHASE_BITS-1 -: QuadBits+2];
  assign k   = pos[QuadBits-1:0];
  assign idx = pos[QuadBits] ? ((QuadBits+1)'(SINE_TABLE_DEPTH) - {1'b0, k}) : {1'b0, k};
  assign mag = $signed({1'b0, rom[idx]});

  assign tri_d   = $signed({1'b0, u, 1'b0}) - 18'sd65536;
  assign tri_abs = (tri_d < 0) ? -tri_d : tri_d;

  always_comb begin
    pw = cfg.pulse_width;
    if (pw < mwpo_pkg::PW_MIN) begin
      pw = mwpo_pkg::PW_MIN;
    end
    if (pw > mwpo_pkg::PW_MAX) begin
      pw = mwpo_pkg::PW_MAX;
    end
  end

  always_comb begin
    case (cfg.waveform)
      mwpo_pkg::WAVE_SQUARE: begin
        raw_next = u[15] ? -17'sd32768 : 17'sd32768;
      end
      mwpo_pkg::WAVE_SAW: begin
        raw_next = $signed({1'b0, u}) - 17'sd32768;
      end
      mwpo_pkg::WAVE_TRIANGLE: begin
        raw_next = 17'(tri_abs - 18'sd32768);
      end
      mwpo_pkg::WAVE_PULSE: begin
        raw_next = (u < pw) ? 17'sd32768 : -17'sd32768;
      end
      mwpo_pkg::WAVE_NOISE: begin
        raw_next = 17'($signed(noise[31:16]));
      end
      default: begin
        raw_next = pos[QuadBits+1] ? -mag : mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw <= raw_next;
    end
  end

endmodule

[hw/rtl/mwpo_scale.sv]
module mwpo_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] raw,
  input  mwpo_pkg::cfg_t     cfg,
  output logic signed [15:0] sample,
  output logic signed [15:0] voltage_out
);

  logic signed [33:0] gain_prod;
  logic signed [19:0] gain_round;
  logic signed [15:0] sample_next;
  logic signed [15:0] sample_mid;
  logic signed [21:0] volt_prod;
  logic signed [21:0] volt_round;

  assign gain_prod  = 34'(raw) * 34'($signed({1'b0, cfg.amplitude}));
  assign gain_round = 20'((gain_prod + 34'sd8192) >>> 14);

  always_comb begin
    if (gain_round > 20'sd32767) begin
      sample_next = 16'sd32767;
    end else if (gain_round < -20'sd32768) begin
      sample_next = -16'sd32768;
    end else begin
      sample_next = gain_round[15:0];
    end
  end

  assign volt_prod  = 22'(sample_mid) *
                      22'($signed({1'b0, mwpo_pkg::range_volts(cfg.voltage_range)}));
  assign volt_round = (volt_prod + 22'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (en) begin
      sample_mid  <= sample_next;
      sample      <= sample_mid;
      voltage_out <= volt_round[15:0];
    end
  end

endmodule

[hw/rtl/multiwave_phase_oscillator_top.sv]
// An accepted word goes through the phase, raw, sample_mid and sample registers.
// Throughput: one word per cycle; the phase loop is a single adder per word.
// The pipeline stalls as a whole only while a result is held on the output.
// SINE_TABLE_DEPTH must be a power of two.
// Reset zeroes the phase accumulator, seeds the noise generator with one and
// loads the register defaults; no clearing pass is needed.
module multiwave_phase_oscillator_top #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // phase_step[31:0]
  input  logic        s_tuser,   // sync
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sample[15:0], voltage_out[31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mwpo_pkg::cfg_t        cfg;
  logic                  en;
  logic                  accept;
  logic [2:0]            valid_pipe;
  logic [PHASE_BITS-1:0] phase;
  logic [31:0]           noise;
  logic signed [16:0]    raw;
  logic signed [15:0]    sample;
  logic signed [15:0]    voltage_out;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign accept    = s_tvalid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform      <= mwpo_pkg::WAVE_SINE;
      cfg.amplitude     <= mwpo_pkg::AMPLITUDE_RESET;
      cfg.pulse_width   <= mwpo_pkg::PULSE_WIDTH_RESET;
      cfg.min_step      <= mwpo_pkg::MIN_STEP_RESET;
      cfg.voltage_range <= mwpo_pkg::RANGE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mwpo_pkg::CFG_WAVEFORM:      cfg.waveform      <= cfg_data[2:0];
        mwpo_pkg::CFG_AMPLITUDE:     cfg.amplitude     <= cfg_data[15:0];
        mwpo_pkg::CFG_PULSE_WIDTH:   cfg.pulse_width   <= cfg_data[15:0];
        mwpo_pkg::CFG_MIN_STEP:      cfg.min_step      <= cfg_data;
        mwpo_pkg::CFG_VOLTAGE_RANGE: cfg.voltage_range <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // advance the valid flags with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
      m_tvalid   <= 1'b0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[1:0], s_tvalid};
      m_tvalid   <= valid_pipe[2];
    end
  end

  mwpo_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .phase_step(s_tdata),
    .sync      (s_tuser),
    .cfg       (cfg),
    .phase     (phase),
    .noise     (noise)
  );

  mwpo_wave #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_wave (
    .clk  (clk),
    .en   (en),
    .phase(phase),
    .noise(noise),
    .cfg  (cfg),
    .raw  (raw)
  );

  mwpo_scale u_scale (
    .clk        (clk),
    .en         (en),
    .raw        (raw),
    .cfg        (cfg),
    .sample     (sample),
    .voltage_out(voltage_out)
  );

  assign m_tdata = {voltage_out, sample};

endmodule
